// ===== rtl/jsd_pkg.sv =====
// Types and constants shared by the joystick scale and direction block.
package jsd_pkg;

  localparam int unsigned RAW_W      = 8;
  localparam int unsigned PCT_W      = 8;
  localparam int unsigned QUOT_W     = 7;
  localparam int unsigned NUM_W      = 15;
  localparam logic [RAW_W-1:0] FULL_SCALE   = 8'd255;
  localparam logic [RAW_W-1:0] CENTER_RESET = 8'd128;
  localparam logic [QUOT_W-1:0] PERCENT     = 7'd100;
  localparam logic [QUOT_W-1:0] NEUTRAL_BAND = 7'd2;

  typedef enum logic [2:0] {
    HEAD_NEUTRAL = 3'd0,
    HEAD_UP      = 3'd1,
    HEAD_DOWN    = 3'd2,
    HEAD_LEFT    = 3'd3,
    HEAD_RIGHT   = 3'd4
  } heading_t;

  typedef struct packed {
    logic [RAW_W-1:0] raw_x;
    logic [RAW_W-1:0] raw_y;
  } in_t;

  typedef struct packed {
    logic signed [PCT_W-1:0] percent_x;
    logic signed [PCT_W-1:0] percent_y;
    heading_t                heading;
  } out_t;

endpackage

// ===== rtl/joystick_scale_and_direction_core.sv =====
// Joystick scale and direction core: five-stage pipelined axis scaler.
//
// Input: raise start with in_req for one cycle; the transaction is taken at
// a rising edge where start is high and busy is low. busy is high during reset
// and until the first edge after rst_n is released, then stays low, so a new
// transaction can enter every cycle.
// Output: out_valid marks out_res for exactly one cycle; the receiver cannot
// stall, so nothing holds the pipeline.
// An accepted transaction passes through the five register stages (offset,
// multiply by 100, quotient bits 6..4, bits 3..0, sign and heading), and
// out_valid marks its result after the last. Throughput: one transaction
// per cycle.
// Config: cfg_ready is always high; cfg_data sets the shared center reading.
// It is sampled by the first stage, so write it only while the pipe is empty.
// Reset: rst_n low clears all valid bits and sets the center to 128.
module joystick_scale_and_direction_core
  import jsd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_t              in_req,
  output logic             out_valid,
  output out_t             out_res,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [RAW_W-1:0] cfg_data
);

  logic             busy_r;
  logic [RAW_W-1:0] center_r;

  logic             v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic [RAW_W-1:0] diff1_r [2];
  logic [RAW_W-1:0] div1_r  [2];
  logic             neg1_r  [2];
  logic [NUM_W-1:0] num2_r  [2];
  logic [RAW_W-1:0] div2_r  [2];
  logic             neg2_r  [2];
  logic [NUM_W-1:0] rem3_r  [2];
  logic [2:0]       q3_r    [2];
  logic [RAW_W-1:0] div3_r  [2];
  logic             neg3_r  [2];
  logic [QUOT_W-1:0] q4_r   [2];
  logic             neg4_r  [2];
  out_t             out_res_r;

  logic [RAW_W-1:0] raw_s   [2];
  logic [RAW_W-1:0] diff1_nxt [2];
  logic [RAW_W-1:0] div1_nxt  [2];
  logic             neg1_nxt  [2];
  logic [NUM_W-1:0] rem3_nxt  [2];
  logic [2:0]       q3_nxt    [2];
  logic [QUOT_W-1:0] q4_nxt   [2];
  out_t             out_res_nxt;
  logic             accept;

  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  assign raw_s[0] = in_req.raw_x;
  assign raw_s[1] = in_req.raw_y;

  // stage 1: offset from center and divisor
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      if (raw_s[a] < center_r) begin
        diff1_nxt[a] = center_r - raw_s[a];
        div1_nxt[a]  = center_r;
        neg1_nxt[a]  = 1'b1;
      end else if (raw_s[a] > center_r) begin
        diff1_nxt[a] = raw_s[a] - center_r;
        div1_nxt[a]  = FULL_SCALE - center_r;
        neg1_nxt[a]  = 1'b0;
      end else begin
        diff1_nxt[a] = '0;
        div1_nxt[a]  = RAW_W'(1);
        neg1_nxt[a]  = 1'b0;
      end
    end
  end

  // stage 3: restoring divide, quotient bits 6..4
  always_comb begin
    logic [NUM_W-1:0] rem;
    logic [NUM_W-1:0] trial;
    for (int a = 0; a < 2; a++) begin
      rem = num2_r[a];
      for (int k = 2; k >= 0; k--) begin
        trial = NUM_W'(div2_r[a]) << (k + 4);
        q3_nxt[a][k] = (rem >= trial);
        if (rem >= trial) begin
          rem = rem - trial;
        end
      end
      rem3_nxt[a] = rem;
    end
  end

  // stage 4: quotient bits 3..0
  always_comb begin
    logic [NUM_W-1:0] rem;
    logic [NUM_W-1:0] trial;
    for (int a = 0; a < 2; a++) begin
      rem = rem3_r[a];
      q4_nxt[a][QUOT_W-1:4] = q3_r[a];
      for (int k = 3; k >= 0; k--) begin
        trial = NUM_W'(div3_r[a]) << k;
        q4_nxt[a][k] = (rem >= trial);
        if (rem >= trial) begin
          rem = rem - trial;
        end
      end
    end
  end

  // stage 5: sign and heading
  always_comb begin
    logic xn, xp, yn, yp, vert;
    xn = neg4_r[0] && (q4_r[0] != '0);
    xp = !neg4_r[0] && (q4_r[0] != '0);
    yn = neg4_r[1] && (q4_r[1] != '0);
    yp = !neg4_r[1] && (q4_r[1] != '0);
    vert = q4_r[1] > q4_r[0];
    out_res_nxt.percent_x = neg4_r[0] ? -PCT_W'(q4_r[0]) : PCT_W'(q4_r[0]);
    out_res_nxt.percent_y = neg4_r[1] ? -PCT_W'(q4_r[1]) : PCT_W'(q4_r[1]);
    priority if (q4_r[0] < NEUTRAL_BAND && q4_r[1] < NEUTRAL_BAND) begin
      out_res_nxt.heading = HEAD_NEUTRAL;
    end else if (!xn && yp) begin
      out_res_nxt.heading = vert ? HEAD_UP : HEAD_RIGHT;
    end else if (xn && !yn) begin
      out_res_nxt.heading = vert ? HEAD_UP : HEAD_LEFT;
    end else if (!xp && yn) begin
      out_res_nxt.heading = vert ? HEAD_DOWN : HEAD_LEFT;
    end else begin
      out_res_nxt.heading = vert ? HEAD_DOWN : HEAD_RIGHT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      center_r    <= CENTER_RESET;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        center_r <= cfg_data;
      end
      v1_r        <= accept;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 2; a++) begin
      diff1_r[a] <= diff1_nxt[a];
      div1_r[a]  <= div1_nxt[a];
      neg1_r[a]  <= neg1_nxt[a];
      num2_r[a]  <= NUM_W'(diff1_r[a]) * NUM_W'(PERCENT);
      div2_r[a]  <= div1_r[a];
      neg2_r[a]  <= neg1_r[a];
      rem3_r[a]  <= rem3_nxt[a];
      q3_r[a]    <= q3_nxt[a];
      div3_r[a]  <= div2_r[a];
      neg3_r[a]  <= neg2_r[a];
      q4_r[a]    <= q4_nxt[a];
      neg4_r[a]  <= neg3_r[a];
    end
    out_res_r <= out_res_nxt;
  end

endmodule

// ===== rtl/jsd_checker.sv =====
// Port-level checker for the joystick scale and direction core, with bind.
module jsd_checker
  import jsd_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input in_t              in_req,
  input logic             out_valid,
  input out_t             out_res,
  input logic             cfg_valid,
  input logic             cfg_ready,
  input logic [RAW_W-1:0] cfg_data
);

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##5 out_valid)
    else $error("accepted transaction produced no result after five cycles");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 5))
    else $error("result without matching transaction");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_res.percent_x <= 8'sd100 && out_res.percent_x >= -8'sd100 &&
                   out_res.percent_y <= 8'sd100 && out_res.percent_y >= -8'sd100))
    else $error("percentage out of range");

  a_neutral: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.heading == HEAD_NEUTRAL) |->
      ((out_res.percent_x == 8'sd0 || out_res.percent_x == 8'sd1 ||
        out_res.percent_x == -8'sd1) &&
       (out_res.percent_y == 8'sd0 || out_res.percent_y == 8'sd1 ||
        out_res.percent_y == -8'sd1)))
    else $error("neutral heading outside the dead band");

endmodule

bind joystick_scale_and_direction_core jsd_checker u_jsd_checker (.*);

// ===== tb/joystick_scale_and_direction_core_tb.sv =====
// Self-checking testbench for the joystick scale and direction core.
module joystick_scale_and_direction_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import jsd_pkg::*;

  localparam int PIPE_LAT  = 5;
  localparam int MAX_SHOWN = 10;

  typedef enum logic [1:0] {STEP_SAMPLE, STEP_CENTER, STEP_SETTLE} step_kind_t;

  typedef struct {
    step_kind_t       kind;
    in_t              sample;
    logic [RAW_W-1:0] center;
    int               gap;
  } step_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  in_t              in_req = '0;
  logic             out_valid;
  out_t             out_res;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [RAW_W-1:0] cfg_data = '0;

  step_t            plan[$];
  out_t             pending_res[$];
  logic [RAW_W-1:0] center_model = CENTER_RESET;
  int               gap_left = 0;
  int               quiet_cycles = 0;
  int               errors = 0;
  int               n_samples = 0;
  int               n_centers = 0;
  int               n_results = 0;
  int               head_seen[0:7];

  joystick_scale_and_direction_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int scale_percent(logic [RAW_W-1:0] raw, logic [RAW_W-1:0] c);
    int r;
    int m;
    r = raw;
    m = c;
    if (r < m) return -(((m - r) * int'(PERCENT)) / m);
    if (r > m) return ((r - m) * int'(PERCENT)) / (int'(FULL_SCALE) - m);
    return 0;
  endfunction

  function automatic heading_t heading_for(int px, int py);
    int  band;
    bit  vert;
    band = int'(NEUTRAL_BAND);
    if (px < band && px > -band && py < band && py > -band) return HEAD_NEUTRAL;
    vert = ((py < 0) ? -py : py) > ((px < 0) ? -px : px);
    if (px >= 0 && py > 0) return vert ? HEAD_UP : HEAD_RIGHT;
    if (px < 0 && py >= 0) return vert ? HEAD_UP : HEAD_LEFT;
    if (px <= 0 && py < 0) return vert ? HEAD_DOWN : HEAD_LEFT;
    return vert ? HEAD_DOWN : HEAD_RIGHT;
  endfunction

  function automatic out_t predict_sample(in_t s, logic [RAW_W-1:0] c);
    out_t r;
    int   px;
    int   py;
    px = scale_percent(s.raw_x, c);
    py = scale_percent(s.raw_y, c);
    r.percent_x = px[PCT_W-1:0];
    r.percent_y = py[PCT_W-1:0];
    r.heading   = heading_for(px, py);
    return r;
  endfunction

  task automatic add_sample(int x, int y, int gap);
    step_t s;
    s.kind   = STEP_SAMPLE;
    s.sample = '{raw_x: x[RAW_W-1:0], raw_y: y[RAW_W-1:0]};
    s.center = '0;
    s.gap    = gap;
    plan.push_back(s);
  endtask

  task automatic add_center(int c);
    step_t s;
    s.kind   = STEP_CENTER;
    s.sample = '0;
    s.center = c[RAW_W-1:0];
    s.gap    = 0;
    plan.push_back(s);
  endtask

  task automatic add_settle();
    step_t s;
    s.kind   = STEP_SETTLE;
    s.sample = '0;
    s.center = '0;
    s.gap    = 0;
    plan.push_back(s);
  endtask

  function automatic int pick_raw(int c);
    int v;
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 255;
      2, 3: begin
        v = c + int'($urandom_range(0, 8)) - 4;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v;
      end
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic int pick_gap(bit busy_phase);
    if (!busy_phase) return 0;
    case ($urandom_range(0, 19))
      12, 13, 14, 15, 16, 17: return $urandom_range(1, 3);
      18, 19: return $urandom_range(8, 40);
      default: return 0;
    endcase
  endfunction

  // drive side: issues transactions and center writes, predicts on acceptance
  always @(posedge clk) begin
    logic  nxt_start;
    logic  nxt_cfg;
    step_t s;
    if (!rst_n) begin
      start     <= 1'b0;
      cfg_valid <= 1'b0;
      gap_left   = 0;
    end else begin
      nxt_start = start;
      nxt_cfg   = cfg_valid;
      if (start && !busy) begin
        pending_res.push_back(predict_sample(in_req, center_model));
        n_samples++;
        nxt_start = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        center_model = cfg_data;
        n_centers++;
        nxt_cfg = 1'b0;
      end
      if (pending_res.size() == 0 && !nxt_start) quiet_cycles++;
      else quiet_cycles = 0;
      if (!nxt_start && !nxt_cfg) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (plan.size() > 0) begin
          s = plan[0];
          case (s.kind)
            STEP_SAMPLE: begin
              void'(plan.pop_front());
              in_req   <= s.sample;
              nxt_start = 1'b1;
              gap_left  = s.gap;
            end
            STEP_CENTER: begin
              if (quiet_cycles > PIPE_LAT) begin
                void'(plan.pop_front());
                cfg_data <= s.center;
                nxt_cfg   = 1'b1;
              end
            end
            default: begin
              if (quiet_cycles > PIPE_LAT) void'(plan.pop_front());
            end
          endcase
        end
      end
      start     <= nxt_start;
      cfg_valid <= nxt_cfg;
    end
  end

  // result side
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid) begin
      n_results++;
      if (pending_res.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("%0t: unexpected result x=%0d y=%0d heading=%0d", $realtime,
                   out_res.percent_x, out_res.percent_y, out_res.heading);
      end else begin
        want = pending_res.pop_front();
        head_seen[want.heading]++;
        if (out_res.percent_x !== want.percent_x || out_res.percent_y !== want.percent_y ||
            out_res.heading !== want.heading) begin
          errors++;
          if (errors <= MAX_SHOWN)
            $display("%0t: mismatch expected x=%0d y=%0d heading=%0d, got x=%0d y=%0d heading=%0d",
                     $realtime, want.percent_x, want.percent_y, want.heading,
                     out_res.percent_x, out_res.percent_y, out_res.heading);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d samples pending", plan.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int  centers[$];
    int  n_phase;
    int  settle_at;
    int  x;
    bit  gappy;
    foreach (head_seen[i]) head_seen[i] = 0;

    // reset center: extremes, neutral band edges, quadrant bounds, ties; then centers 0 and 255
    add_sample(0, 0, 0);
    add_sample(255, 255, 0);
    add_sample(128, 128, 1);
    add_sample(0, 255, 0);
    add_sample(255, 0, 0);
    add_sample(130, 128, 0);
    add_sample(131, 128, 0);
    add_sample(126, 128, 2);
    add_sample(125, 128, 0);
    add_sample(128, 130, 0);
    add_sample(128, 131, 0);
    add_sample(128, 125, 0);
    add_sample(200, 200, 0);
    add_sample(56, 56, 0);
    add_sample(56, 200, 0);
    add_sample(200, 56, 0);
    add_sample(128, 255, 0);
    add_sample(128, 0, 0);
    add_sample(0, 128, 0);
    add_sample(255, 128, 0);
    add_center(0);
    add_sample(0, 0, 0);
    add_sample(255, 255, 0);
    add_sample(0, 255, 0);
    add_sample(1, 2, 0);
    add_center(255);
    add_sample(255, 255, 0);
    add_sample(0, 0, 0);
    add_sample(254, 0, 0);

    centers = '{0, 255, 1, 254, 127};
    repeat (5) centers.push_back($urandom_range(0, 255));
    centers.push_back(128);
    foreach (centers[p]) begin
      add_center(centers[p]);
      n_phase   = 150;
      settle_at = $urandom_range(20, n_phase - 20);
      gappy     = (p % 3) != 0;
      for (int i = 0; i < n_phase; i++) begin
        if (i == settle_at) add_settle();
        x = pick_raw(centers[p]);
        if ($urandom_range(0, 9) == 0) add_sample(x, x, pick_gap(gappy));
        else add_sample(x, pick_raw(centers[p]), pick_gap(gappy));
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (plan.size() != 0 || start || cfg_valid || pending_res.size() != 0)
      @(posedge clk);
    repeat (PIPE_LAT + 3) @(posedge clk);

    $display("Checked %0d of %0d samples across %0d center settings, %0d mismatches",
             n_results, n_samples, n_centers + 1, errors);
    $display("Headings seen: neutral %0d, up %0d, down %0d, left %0d, right %0d",
             head_seen[HEAD_NEUTRAL], head_seen[HEAD_UP], head_seen[HEAD_DOWN],
             head_seen[HEAD_LEFT], head_seen[HEAD_RIGHT]);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
